>>> sv/iapw_pkg.sv
`default_nettype none

package iapw_pkg;

   // Store geometry and fixed point format
   localparam int MaxWidth     = 1024;
   localparam int MaxHeight    = 1024;
   localparam int CoefFracBits = 16;

   // Field widths
   localparam int CoefW   = 32;
   localparam int PosW    = 10;
   localparam int ColorW  = 8;
   localparam int DimW    = 11;
   localparam int RgbW    = 3 * ColorW;
   localparam int NumRegs = 8;
   localparam int CsrIdxW = $clog2(NumRegs);

   // Store addressing: row-major, row stride MaxWidth
   localparam int ColBits = $clog2(MaxWidth);
   localparam int RowBits = $clog2(MaxHeight);
   localparam int AddrW   = ColBits + RowBits;
   localparam int Depth   = MaxWidth * MaxHeight;

   // Datapath widths: coefficient times zero-extended position, then a three-term sum
   localparam int ProdW = CoefW + PosW + 1;
   localparam int SumW  = ProdW + 2;
   localparam int SxW   = SumW - CoefFracBits;

   localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) << (CoefFracBits - 1);

   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);

   localparam logic CmdWrite   = 1'b0;
   localparam logic CmdRequest = 1'b1;

   typedef enum logic [CsrIdxW-1:0] {
      RegCoefXx      = 3'd0,
      RegCoefXy      = 3'd1,
      RegOffsetX     = 3'd2,
      RegCoefYx      = 3'd3,
      RegCoefYy      = 3'd4,
      RegOffsetY     = 3'd5,
      RegImageWidth  = 3'd6,
      RegImageHeight = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      KindWrite,
      KindHit,
      KindMiss
   } kind_type;

   typedef struct packed {
      logic              cmd;
      logic [PosW-1:0]   pos_x;
      logic [PosW-1:0]   pos_y;
      logic [ColorW-1:0] in_red;
      logic [ColorW-1:0] in_green;
      logic [ColorW-1:0] in_blue;
   } req_payload_type;

   typedef struct packed {
      logic              hit;
      logic [ColorW-1:0] out_red;
      logic [ColorW-1:0] out_green;
      logic [ColorW-1:0] out_blue;
   } rsp_payload_type;

   typedef struct packed {
      kind_type         kind;
      logic [AddrW-1:0] addr;
      logic [RgbW-1:0]  rgb;
   } entry_type;

   // Push side of the queue
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Pop side of the queue
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

`default_nettype wire

>>> sv/inverse_affine_pixel_warp.sv
`default_nettype none

// Channel  | Handshake            | Payload
// req      | req_valid/req_stall  | req_data   (cmd, pos_x, pos_y, in_red/green/blue)
// rsp      | rsp_valid/rsp_stall  | rsp_data   (hit, out_red/green/blue)
// csr      | csr_wr_en            | csr_index, csr_wdata
//
// One request accepted per cycle while req_stall is low; a read request passes
// through the products stage, the sums, the bounds check, the queue, the image
// RAM's registered read and the output register, in that order, before it
// raises rsp_valid. Writes give no result.
// Reset clears control state only; image contents are undefined until written.
// req_stall rises only when the four-entry queue is full and the front is loaded.

module inverse_affine_pixel_warp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [iapw_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [iapw_pkg::CoefW-1:0]    csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire iapw_pkg::req_payload_type     req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output iapw_pkg::rsp_payload_type          rsp_data
);

   iapw_pkg::push_type push;
   iapw_pkg::head_type head;
   logic               q_full, pop;

   iapw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_full   (q_full),
      .push     (push)
   );

   iapw_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .full (q_full),
      .pop  (pop),
      .head (head)
   );

   iapw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> sv/iapw_ram.sv
`default_nettype none

module iapw_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/iapw_front.sv
`default_nettype none

module iapw_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [iapw_pkg::CsrIdxW-1:0]         csr_index,
   input  wire logic [iapw_pkg::CoefW-1:0]           csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire iapw_pkg::req_payload_type            req_data,
   input  wire logic                                 q_full,
   output iapw_pkg::push_type                        push
);

   localparam int SumW = iapw_pkg::SumW;
   localparam int ProdW = iapw_pkg::ProdW;
   localparam int SxW = iapw_pkg::SxW;
   localparam int Frac = iapw_pkg::CoefFracBits;

   logic signed [iapw_pkg::CoefW-1:0] coef_xx_ff, coef_xy_ff, offset_x_ff;
   logic signed [iapw_pkg::CoefW-1:0] coef_yx_ff, coef_yy_ff, offset_y_ff;
   logic [iapw_pkg::DimW-1:0]         width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff  <= iapw_pkg::CoefW'(32'sd65536);
         coef_xy_ff  <= '0;
         offset_x_ff <= '0;
         coef_yx_ff  <= '0;
         coef_yy_ff  <= iapw_pkg::CoefW'(32'sd65536);
         offset_y_ff <= '0;
         width_ff    <= iapw_pkg::DimW'(1024);
         height_ff   <= iapw_pkg::DimW'(1024);
      end else if (csr_wr_en) begin
         case (csr_index)
            iapw_pkg::RegCoefXx:      coef_xx_ff  <= csr_wdata;
            iapw_pkg::RegCoefXy:      coef_xy_ff  <= csr_wdata;
            iapw_pkg::RegOffsetX:     offset_x_ff <= csr_wdata;
            iapw_pkg::RegCoefYx:      coef_yx_ff  <= csr_wdata;
            iapw_pkg::RegCoefYy:      coef_yy_ff  <= csr_wdata;
            iapw_pkg::RegOffsetY:     offset_y_ff <= csr_wdata;
            iapw_pkg::RegImageWidth:  width_ff    <= csr_wdata[iapw_pkg::DimW-1:0];
            iapw_pkg::RegImageHeight: height_ff   <= csr_wdata[iapw_pkg::DimW-1:0];
            default: ;
         endcase
      end
   end

   // Clamp dimensions to the store size
   logic [SxW-1:0] w_ext, h_ext, w_eff, h_eff;

   always_comb begin
      w_ext = SxW'(width_ff);
      h_ext = SxW'(height_ff);
      w_eff = (w_ext > SxW'(iapw_pkg::MaxWidth)) ? SxW'(iapw_pkg::MaxWidth) : w_ext;
      h_eff = (h_ext > SxW'(iapw_pkg::MaxHeight)) ? SxW'(iapw_pkg::MaxHeight) : h_ext;
   end

   logic en;
   logic s3_valid_ff;

   // Whole front advances together; hold while the last stage cannot push
   assign en        = !q_full || !s3_valid_ff;
   assign req_stall = !en;

   // Stage 1: products
   logic                         s1_valid_ff, s1_valid_in, wr_ok;
   logic                         s1_cmd_ff;
   logic [iapw_pkg::PosW-1:0]    s1_px_ff, s1_py_ff;
   logic [iapw_pkg::RgbW-1:0]    s1_rgb_ff;
   logic signed [ProdW-1:0]      s1_pxx_ff, s1_pxy_ff, s1_pyx_ff, s1_pyy_ff;
   logic signed [SumW-1:0]       s1_offx_ff, s1_offy_ff;
   logic signed [iapw_pkg::PosW:0] x_s, y_s;

   always_comb begin
      x_s   = $signed({1'b0, req_data.pos_x});
      y_s   = $signed({1'b0, req_data.pos_y});
      wr_ok = (SxW'(req_data.pos_x) < w_eff) && (SxW'(req_data.pos_y) < h_eff);
      // Drop writes outside the image here
      s1_valid_in = req_valid && ((req_data.cmd == iapw_pkg::CmdRequest) || wr_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff  <= req_data.cmd;
         s1_px_ff   <= req_data.pos_x;
         s1_py_ff   <= req_data.pos_y;
         s1_rgb_ff  <= {req_data.in_red, req_data.in_green, req_data.in_blue};
         s1_pxx_ff  <= ProdW'(coef_xx_ff) * ProdW'(x_s);
         s1_pxy_ff  <= ProdW'(coef_xy_ff) * ProdW'(y_s);
         s1_pyx_ff  <= ProdW'(coef_yx_ff) * ProdW'(x_s);
         s1_pyy_ff  <= ProdW'(coef_yy_ff) * ProdW'(y_s);
         // Fold the rounding bias into the offset
         s1_offx_ff <= SumW'(offset_x_ff) + iapw_pkg::RoundHalf;
         s1_offy_ff <= SumW'(offset_y_ff) + iapw_pkg::RoundHalf;
      end
   end

   // Stage 2: biased sums
   logic                      s2_valid_ff, s2_cmd_ff;
   logic [iapw_pkg::PosW-1:0] s2_px_ff, s2_py_ff;
   logic [iapw_pkg::RgbW-1:0] s2_rgb_ff;
   logic signed [SumW-1:0]    s2_tx_ff, s2_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_rgb_ff <= s1_rgb_ff;
         s2_tx_ff  <= SumW'(s1_pxx_ff) + SumW'(s1_pxy_ff) + s1_offx_ff;
         s2_ty_ff  <= SumW'(s1_pyx_ff) + SumW'(s1_pyy_ff) + s1_offy_ff;
      end
   end

   // Stage 3: classify. With the bias added, the rounded coordinate is the
   // integer part, and it is in range only when the biased sum is positive.
   iapw_pkg::entry_type s3_entry_ff, s3_entry_in;
   logic [SxW-1:0]      sx_full, sy_full;
   logic                in_x, in_y;

   always_comb begin
      sx_full = s2_tx_ff[SumW-1:Frac];
      sy_full = s2_ty_ff[SumW-1:Frac];
      in_x    = !s2_tx_ff[SumW-1] && (s2_tx_ff != '0) && (sx_full < w_eff);
      in_y    = !s2_ty_ff[SumW-1] && (s2_ty_ff != '0) && (sy_full < h_eff);
      s3_entry_in.rgb = s2_rgb_ff;
      if (s2_cmd_ff == iapw_pkg::CmdWrite) begin
         s3_entry_in.kind = iapw_pkg::KindWrite;
         s3_entry_in.addr = {iapw_pkg::RowBits'(s2_py_ff), iapw_pkg::ColBits'(s2_px_ff)};
      end else begin
         s3_entry_in.kind = (in_x && in_y) ? iapw_pkg::KindHit : iapw_pkg::KindMiss;
         s3_entry_in.addr = {s2_ty_ff[Frac +: iapw_pkg::RowBits],
                             s2_tx_ff[Frac +: iapw_pkg::ColBits]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_entry_ff <= s3_entry_in;
      end
   end

   assign push.valid = s3_valid_ff;
   assign push.entry = s3_entry_ff;

endmodule

`default_nettype wire

>>> sv/iapw_queue.sv
`default_nettype none

module iapw_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire iapw_pkg::push_type  push,
   output logic                     full,
   input  wire logic                pop,
   output iapw_pkg::head_type       head
);

   localparam int PtrW = iapw_pkg::QPtrW;

   iapw_pkg::entry_type   slot_ff [iapw_pkg::QueueDepth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]         count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      full     = (count_ff == (PtrW+1)'(iapw_pkg::QueueDepth));
      do_push  = push.valid && !full;
      do_pop   = pop && (count_ff != '0);
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
      head.valid = (count_ff != '0);
      head.entry = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/iapw_back.sv
`default_nettype none

module iapw_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire iapw_pkg::head_type        head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output iapw_pkg::rsp_payload_type      rsp_data
);

   logic                      out_can, b1_can, is_write, is_hit;
   logic                      ram_we, ram_re;
   logic [iapw_pkg::RgbW-1:0] ram_rd;
   logic                      b1_valid_ff, b1_valid_in, b1_hit_ff, b1_hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   iapw_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   always_comb begin
      out_can  = !rsp_valid_ff || !rsp_stall;
      b1_can   = !b1_valid_ff || out_can;
      is_write = (head.entry.kind == iapw_pkg::KindWrite);
      is_hit   = (head.entry.kind == iapw_pkg::KindHit);
      // Writes need no result slot and drain even while the output is held
      pop      = head.valid && (is_write || b1_can);
      ram_we   = pop && is_write;
      ram_re   = pop && is_hit;

      b1_valid_in = b1_valid_ff;
      b1_hit_in   = b1_hit_ff;
      if (b1_can) begin
         b1_valid_in = pop && !is_write;
         b1_hit_in   = is_hit;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_can) begin
         rsp_valid_in = b1_valid_ff;
         if (b1_hit_ff) begin
            rsp_data_in.hit       = 1'b1;
            rsp_data_in.out_red   = ram_rd[2*iapw_pkg::ColorW +: iapw_pkg::ColorW];
            rsp_data_in.out_green = ram_rd[iapw_pkg::ColorW +: iapw_pkg::ColorW];
            rsp_data_in.out_blue  = ram_rd[0 +: iapw_pkg::ColorW];
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   iapw_ram #(
      .Width(iapw_pkg::RgbW),
      .Depth(iapw_pkg::Depth)
   ) u_image (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(head.entry.addr),
      .wr_data(head.entry.rgb),
      .rd_en  (ram_re),
      .rd_addr(head.entry.addr),
      .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_hit_ff   <= b1_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> sv/iapw_checker.sv
`default_nettype none

module iapw_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire iapw_pkg::rsp_payload_type     rsp_data
);

   // Output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Front is empty after reset, so it must take the first request
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall)
      else $error("stall right after reset");

   // A miss carries black
   a_miss_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.out_red == '0 && rsp_data.out_green == '0 && rsp_data.out_blue == '0)
      else $error("miss with non-zero colour");

   // Held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind inverse_affine_pixel_warp iapw_checker u_checker (.*);

`default_nettype wire
